FILE: src/chtbl_pkg.sv
`default_nettype none

package chtbl_pkg;

   // input function codes
   localparam logic [2:0] FUNC_OPEN       = 3'd0;
   localparam logic [2:0] FUNC_CONNECT    = 3'd1;
   localparam logic [2:0] FUNC_DISCONNECT = 3'd2;
   localparam logic [2:0] FUNC_CLOSE      = 3'd3;
   localparam logic [2:0] FUNC_SEGMENT    = 3'd4;
   localparam logic [2:0] FUNC_TICK       = 3'd5;

   // received segment types
   localparam logic [2:0] RX_SYNACK = 3'd1;
   localparam logic [2:0] RX_FINACK = 3'd3;

   // transmitted segment types
   localparam logic [1:0] SEG_SYN = 2'd0;
   localparam logic [1:0] SEG_FIN = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_SYN_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_SYN_RETRY   = 2'd1;
   localparam logic [1:0] CSR_FIN_TIMEOUT = 2'd2;
   localparam logic [1:0] CSR_FIN_RETRY   = 2'd3;

   // results kept per transaction
   localparam logic [3:0] MAX_RESULTS = 4'd8;

   typedef enum logic [3:0] {
      KIND_OK           = 4'd0,
      KIND_TABLE_FULL   = 4'd1,
      KIND_NO_ENTRY     = 4'd2,
      KIND_BAD_STATE    = 4'd3,
      KIND_SEND         = 4'd4,
      KIND_CONNECTED    = 4'd5,
      KIND_CONN_FAIL    = 4'd6,
      KIND_DISCONNECTED = 4'd7,
      KIND_DISC_TIMEOUT = 4'd8,
      KIND_REPEAT_ACK   = 4'd9,
      KIND_UNKNOWN_PORT = 4'd10
   } kind_type;

   typedef enum logic [1:0] {
      CS_CLOSED    = 2'd0,
      CS_SYNSENT   = 2'd1,
      CS_CONNECTED = 2'd2,
      CS_FINWAIT   = 2'd3
   } conn_state_type;

   // classified commands handed from front to back
   typedef enum logic [3:0] {
      OP_NONE,
      OP_OPEN,
      OP_CONNECT,
      OP_DISCONNECT,
      OP_CLOSE,
      OP_NOSLOT,
      OP_SYNACK,
      OP_FINACK,
      OP_TICK
   } op_type;

   typedef enum logic [1:0] {
      ES_IDLE,
      ES_SCAN,
      ES_DONE
   } eng_state_type;

   typedef struct packed {
      op_type      op;
      logic [2:0]  slot;
      logic [15:0] port;   // client/server port, or destination port of an ack
   } cmd_type;

   typedef struct packed {
      logic [15:0]    cli_port;
      logic [15:0]    srv_port;
      conn_state_type cstate;
      logic [7:0]     retry;
      logic [15:0]    timer;
   } entry_rec_type;

   typedef struct packed {
      logic [15:0] syn_timeout_ticks;
      logic [7:0]  syn_retry_limit;
      logic [15:0] fin_timeout_ticks;
      logic [7:0]  fin_retry_limit;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [2:0]  entry;
      logic [1:0]  tx_type;
      logic [15:0] tx_src_port;
      logic [15:0] tx_dest_port;
      logic        last;
   } rsp_type;

endpackage

`default_nettype wire

FILE: src/chtbl_fifo.sv
`default_nettype none

module chtbl_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNTW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = store_ff[rd_ptr_ff];

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // hold payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

FILE: src/chtbl_front.sv
`default_nettype none

module chtbl_front #(
   parameter int ENTRIES   = 8,
   parameter int CMD_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [2:0]         req_func,
   input  logic [2:0]         req_slot,
   input  logic [15:0]        req_port,
   input  logic [2:0]         req_rx_type,
   input  logic [15:0]        req_rx_dest_port,
   output logic               cmd_valid,
   output chtbl_pkg::cmd_type cmd,
   input  logic               cmd_pop
);
   import chtbl_pkg::*;

   cmd_type                 cls;
   logic                    slot_in_range;
   logic                    q_push;
   logic                    q_empty;
   logic [$bits(cmd_type)-1:0] q_rdata;

   assign slot_in_range = (7'(req_slot) < 7'(ENTRIES));

   // classify the incoming transaction
   always_comb begin
      cls.op   = OP_NONE;
      cls.slot = req_slot;
      cls.port = req_port;
      case (req_func)
         FUNC_OPEN:       cls.op = OP_OPEN;
         FUNC_CONNECT:    cls.op = slot_in_range ? OP_CONNECT : OP_NOSLOT;
         FUNC_DISCONNECT: cls.op = slot_in_range ? OP_DISCONNECT : OP_NOSLOT;
         FUNC_CLOSE:      cls.op = slot_in_range ? OP_CLOSE : OP_NOSLOT;
         FUNC_SEGMENT: begin
            cls.port = req_rx_dest_port;
            if (req_rx_type == RX_SYNACK) begin
               cls.op = OP_SYNACK;
            end else if (req_rx_type == RX_FINACK) begin
               cls.op = OP_FINACK;
            end
         end
         FUNC_TICK:       cls.op = OP_TICK;
         default:         cls.op = OP_NONE;
      endcase
   end

   // drop transactions that cause nothing, queue the rest
   assign q_push = req_push && !req_full && (cls.op != OP_NONE);

   chtbl_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (cls),
      .full  (req_full),
      .pop   (cmd_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   assign cmd_valid = !q_empty;
   assign cmd       = cmd_type'(q_rdata);

endmodule

`default_nettype wire

FILE: src/chtbl_engine.sv
`default_nettype none

module chtbl_engine #(
   parameter int ENTRIES = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  chtbl_pkg::cfg_type cfg,
   input  logic               cmd_valid,
   input  chtbl_pkg::cmd_type cmd,
   output logic               cmd_pop,
   input  logic               rsp_full,
   output logic               rsp_push,
   output chtbl_pkg::rsp_type rsp_data
);
   import chtbl_pkg::*;

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   // connection table, one read and one write port
   entry_rec_type mem [ENTRIES];
   entry_rec_type rd_ff;
   logic [IW-1:0] rd_idx_ff;
   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic          mem_we;
   entry_rec_type wr;

   eng_state_type      state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic               rdv_ff, rdv_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [3:0]         n_ff, n_in;
   logic               pend_v_ff, pend_v_in;
   rsp_type            pend_ff, pend_in;

   logic          fire, finish;
   rsp_type       new_res;
   logic [IW-1:0] k;
   logic [IW+2:0] k_wide;
   logic [IW+2:0] slot_wide;
   logic [2:0]    ent;
   logic          v, is_last, syn;
   logic [15:0]   tmr_next, tmo;
   logic [7:0]    rty_next, lim;

   assign k         = rd_idx_ff;
   assign k_wide    = (IW + 3)'(k);
   assign ent       = k_wide[2:0];
   assign slot_wide = (IW + 3)'(cmd.slot);
   assign rd_addr   = idx_ff[IW-1:0];
   assign v         = valid_ff[k];
   assign is_last   = (k == IW'(ENTRIES - 1));
   assign syn       = (rd_ff.cstate == CS_SYNSENT);
   assign tmr_next  = rd_ff.timer + 16'd1;
   assign rty_next  = rd_ff.retry + 8'd1;
   assign tmo       = syn ? cfg.syn_timeout_ticks : cfg.fin_timeout_ticks;
   assign lim       = syn ? cfg.syn_retry_limit : cfg.fin_retry_limit;

   // sequencer: take a command, walk the table, release results
   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      idx_in    = idx_ff;
      rdv_in    = rdv_ff;
      valid_in  = valid_ff;
      n_in      = n_ff;
      pend_v_in = pend_v_ff;
      pend_in   = pend_ff;
      cmd_pop   = 1'b0;
      rd_en     = 1'b0;
      mem_we    = 1'b0;
      wr        = rd_ff;
      fire      = 1'b0;
      finish    = 1'b0;
      rsp_push  = 1'b0;
      rsp_data  = pend_ff;
      rsp_data.last = (state_ff == ES_DONE);

      new_res.kind         = KIND_OK;
      new_res.entry        = ent;
      new_res.tx_type      = '0;
      new_res.tx_src_port  = '0;
      new_res.tx_dest_port = '0;
      new_res.last         = 1'b0;

      case (state_ff)
         ES_IDLE: begin
            rdv_in = 1'b0;
            if (cmd_valid) begin
               cmd_pop   = 1'b1;
               cmd_in    = cmd;
               n_in      = '0;
               pend_v_in = 1'b0;
               if (cmd.op == OP_CONNECT || cmd.op == OP_DISCONNECT ||
                   cmd.op == OP_CLOSE) begin
                  idx_in = CW'(slot_wide[IW-1:0]);
               end else begin
                  idx_in = '0;
               end
               state_in = ES_SCAN;
            end
         end

         ES_SCAN: begin
            if (!rsp_full) begin
               // issue the next table read
               if (idx_ff < CW'(ENTRIES)) begin
                  rd_en  = 1'b1;
                  idx_in = idx_ff + CW'(1);
               end
               rdv_in = rd_en;

               if (cmd_ff.op == OP_NOSLOT) begin
                  fire          = 1'b1;
                  finish        = 1'b1;
                  new_res.kind  = KIND_NO_ENTRY;
                  new_res.entry = cmd_ff.slot;
               end else if (rdv_ff) begin
                  case (cmd_ff.op)
                     OP_OPEN: begin
                        if (!v) begin
                           mem_we         = 1'b1;
                           wr.cli_port    = cmd_ff.port;
                           wr.srv_port    = '0;
                           wr.cstate      = CS_CLOSED;
                           wr.retry       = '0;
                           wr.timer       = '0;
                           valid_in[k]    = 1'b1;
                           fire           = 1'b1;
                           finish         = 1'b1;
                        end else if (is_last) begin
                           fire          = 1'b1;
                           finish        = 1'b1;
                           new_res.kind  = KIND_TABLE_FULL;
                           new_res.entry = '0;
                        end
                     end

                     OP_CONNECT: begin
                        fire   = 1'b1;
                        finish = 1'b1;
                        if (!v) begin
                           new_res.kind = KIND_NO_ENTRY;
                        end else begin
                           mem_we               = 1'b1;
                           wr.srv_port          = cmd_ff.port;
                           wr.cstate            = CS_SYNSENT;
                           wr.retry             = '0;
                           wr.timer             = '0;
                           new_res.kind         = KIND_SEND;
                           new_res.tx_type      = SEG_SYN;
                           new_res.tx_src_port  = rd_ff.cli_port;
                           new_res.tx_dest_port = cmd_ff.port;
                        end
                     end

                     OP_DISCONNECT: begin
                        fire   = 1'b1;
                        finish = 1'b1;
                        if (!v) begin
                           new_res.kind = KIND_NO_ENTRY;
                        end else if (rd_ff.cstate != CS_CONNECTED) begin
                           new_res.kind = KIND_BAD_STATE;
                        end else begin
                           mem_we               = 1'b1;
                           wr.cstate            = CS_FINWAIT;
                           wr.retry             = '0;
                           wr.timer             = '0;
                           new_res.kind         = KIND_SEND;
                           new_res.tx_type      = SEG_FIN;
                           new_res.tx_src_port  = rd_ff.cli_port;
                           new_res.tx_dest_port = rd_ff.srv_port;
                        end
                     end

                     OP_CLOSE: begin
                        fire   = 1'b1;
                        finish = 1'b1;
                        if (!v) begin
                           new_res.kind = KIND_NO_ENTRY;
                        end else begin
                           valid_in[k]  = 1'b0;
                           new_res.kind = (rd_ff.cstate == CS_CLOSED) ?
                                          KIND_OK : KIND_BAD_STATE;
                        end
                     end

                     OP_SYNACK: begin
                        if (v && rd_ff.cli_port == cmd_ff.port) begin
                           fire   = 1'b1;
                           finish = 1'b1;
                           if (rd_ff.cstate == CS_SYNSENT) begin
                              mem_we       = 1'b1;
                              wr.cstate    = CS_CONNECTED;
                              new_res.kind = KIND_CONNECTED;
                           end else if (rd_ff.cstate == CS_CONNECTED) begin
                              new_res.kind = KIND_REPEAT_ACK;
                           end else begin
                              new_res.kind = KIND_BAD_STATE;
                           end
                        end else if (is_last) begin
                           fire          = 1'b1;
                           finish        = 1'b1;
                           new_res.kind  = KIND_UNKNOWN_PORT;
                           new_res.entry = '0;
                        end
                     end

                     OP_FINACK: begin
                        if (v && rd_ff.cli_port == cmd_ff.port) begin
                           fire   = 1'b1;
                           finish = 1'b1;
                           if (rd_ff.cstate == CS_FINWAIT) begin
                              mem_we         = 1'b1;
                              wr.cstate      = CS_CLOSED;
                              wr.srv_port    = '0;
                              new_res.kind   = KIND_DISCONNECTED;
                           end else if (rd_ff.cstate == CS_CLOSED) begin
                              new_res.kind = KIND_REPEAT_ACK;
                           end else begin
                              new_res.kind = KIND_BAD_STATE;
                           end
                        end else if (is_last) begin
                           fire          = 1'b1;
                           finish        = 1'b1;
                           new_res.kind  = KIND_UNKNOWN_PORT;
                           new_res.entry = '0;
                        end
                     end

                     OP_TICK: begin
                        finish = is_last;
                        if (v && (rd_ff.cstate == CS_SYNSENT ||
                                  rd_ff.cstate == CS_FINWAIT)) begin
                           mem_we = 1'b1;
                           if (tmr_next < tmo) begin
                              wr.timer = tmr_next;
                           end else begin
                              wr.timer = '0;
                              wr.retry = rty_next;
                              fire     = 1'b1;
                              if (rty_next >= lim) begin
                                 wr.cstate      = CS_CLOSED;
                                 wr.srv_port    = '0;
                                 new_res.kind   = syn ? KIND_CONN_FAIL : KIND_DISC_TIMEOUT;
                              end else begin
                                 new_res.kind         = KIND_SEND;
                                 new_res.tx_type      = syn ? SEG_SYN : SEG_FIN;
                                 new_res.tx_src_port  = rd_ff.cli_port;
                                 new_res.tx_dest_port = rd_ff.srv_port;
                              end
                           end
                        end
                     end

                     default: finish = 1'b1;
                  endcase
               end

               if (finish) begin
                  state_in = ES_DONE;
               end
            end
         end

         ES_DONE: begin
            // release the held result as the final one
            if (!rsp_full) begin
               rsp_push  = pend_v_ff;
               pend_v_in = 1'b0;
               state_in  = ES_IDLE;
            end
         end

         default: state_in = ES_IDLE;
      endcase

      // hold the newest result back until the next one or the end shows up
      if (fire && (n_ff < MAX_RESULTS)) begin
         rsp_push  = pend_v_ff;
         pend_in   = new_res;
         pend_v_in = 1'b1;
         n_in      = n_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ES_IDLE;
         rdv_ff    <= 1'b0;
         valid_ff  <= '0;
         n_ff      <= '0;
         pend_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rdv_ff    <= rdv_in;
         valid_ff  <= valid_in;
         n_ff      <= n_in;
         pend_v_ff <= pend_v_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      idx_ff  <= idx_in;
      pend_ff <= pend_in;
   end

   // table write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[k] <= wr;
      end
      if (rd_en) begin
         rd_ff     <= mem[rd_addr];
         rd_idx_ff <= rd_addr;
      end
   end

endmodule

`default_nettype wire

FILE: src/connection_handshake_table_core.sv
// Channel     Direction  Handshake                      Payload
// req_*       in         push / full                    func, slot, port, rx_type, rx_dest_port
// rsp_*       out        empty / pop                    kind, entry, tx_type, tx_src_port,
//                                                        tx_dest_port, last
// csr_*       in         wen, no wait                   index, wdata
//
// A slot command (connect, disconnect, close) starts its read at its own entry in the back end;
// open, a received ack and a tick walk the table one entry a cycle through its single read port
// while the result queue has room, a search stopping at its first hit.
// Reset is synchronous and empties both queues and marks every entry free.
// A full result queue stalls the table walk; the command queue keeps taking transactions
// until it fills, then full rises.
`default_nettype none

module connection_handshake_table_core #(
   parameter int ENTRIES   = 8,
   parameter int CMD_DEPTH = 2,
   parameter int RSP_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_func,
   input  logic [2:0]  req_slot,
   input  logic [15:0] req_port,
   input  logic [2:0]  req_rx_type,
   input  logic [15:0] req_rx_dest_port,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [3:0]  rsp_kind,
   output logic [2:0]  rsp_entry,
   output logic [1:0]  rsp_tx_type,
   output logic [15:0] rsp_tx_src_port,
   output logic [15:0] rsp_tx_dest_port,
   output logic        rsp_last,
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import chtbl_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    cmd_valid, cmd_pop;
   cmd_type cmd;
   logic    res_full, res_push;
   rsp_type res_data, rsp_q;
   logic [$bits(rsp_type)-1:0] rsp_rdata;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_SYN_TIMEOUT: cfg_in.syn_timeout_ticks = csr_wdata;
            CSR_SYN_RETRY:   cfg_in.syn_retry_limit   = csr_wdata[7:0];
            CSR_FIN_TIMEOUT: cfg_in.fin_timeout_ticks = csr_wdata;
            CSR_FIN_RETRY:   cfg_in.fin_retry_limit   = csr_wdata[7:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.syn_timeout_ticks <= 16'd1000;
         cfg_ff.syn_retry_limit   <= 8'd5;
         cfg_ff.fin_timeout_ticks <= 16'd1000;
         cfg_ff.fin_retry_limit   <= 8'd5;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   chtbl_front #(
      .ENTRIES   (ENTRIES),
      .CMD_DEPTH (CMD_DEPTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_func         (req_func),
      .req_slot         (req_slot),
      .req_port         (req_port),
      .req_rx_type      (req_rx_type),
      .req_rx_dest_port (req_rx_dest_port),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop)
   );

   chtbl_engine #(
      .ENTRIES (ENTRIES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (res_full),
      .rsp_push  (res_push),
      .rsp_data  (res_data)
   );

   chtbl_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .wdata (res_data),
      .full  (res_full),
      .pop   (rsp_pop),
      .rdata (rsp_rdata),
      .empty (rsp_empty)
   );

   assign rsp_q            = rsp_type'(rsp_rdata);
   assign rsp_kind         = rsp_q.kind;
   assign rsp_entry        = rsp_q.entry;
   assign rsp_tx_type      = rsp_q.tx_type;
   assign rsp_tx_src_port  = rsp_q.tx_src_port;
   assign rsp_tx_dest_port = rsp_q.tx_dest_port;
   assign rsp_last         = rsp_q.last;

endmodule

`default_nettype wire

FILE: src/chtbl_checker.sv
`default_nettype none

module chtbl_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_full,
   input wire        rsp_empty,
   input wire        rsp_pop,
   input wire [3:0]  rsp_kind,
   input wire [2:0]  rsp_entry,
   input wire [1:0]  rsp_tx_type,
   input wire [15:0] rsp_tx_src_port,
   input wire [15:0] rsp_tx_dest_port,
   input wire        rsp_last
);
   import chtbl_pkg::*;

   // both queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   // a send transaction carries a SYN or a FIN
   a_send_type: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == KIND_SEND) |->
         (rsp_tx_type == SEG_SYN || rsp_tx_type == SEG_FIN))
      else $error("send result with bad segment type");

   // results other than send leave the segment fields clear
   a_nonsend_clear: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind != KIND_SEND) |->
         (rsp_tx_type == 2'd0 && rsp_tx_src_port == 16'd0 && rsp_tx_dest_port == 16'd0))
      else $error("segment fields set on a non-send result");

   // a result not taken stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_kind) && $stable(rsp_entry) && $stable(rsp_last)))
      else $error("waiting result changed");

endmodule

bind connection_handshake_table_core chtbl_checker u_chtbl_checker (
   .clock            (clock),
   .reset            (reset),
   .req_full         (req_full),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_kind         (rsp_kind),
   .rsp_entry        (rsp_entry),
   .rsp_tx_type      (rsp_tx_type),
   .rsp_tx_src_port  (rsp_tx_src_port),
   .rsp_tx_dest_port (rsp_tx_dest_port),
   .rsp_last         (rsp_last)
);

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
   import chtbl_pkg::*;

   localparam int ENTRIES      = 8;
   localparam int HOLD_CYCLES  = 300;
   localparam int QUIET_CYCLES = 48;

   // codes the package leaves out: ignored segment types, spare function code, empty tx type
   localparam logic [2:0] RX_SYN     = 3'd0;
   localparam logic [2:0] RX_ODD     = 3'd7;
   localparam logic [2:0] FUNC_SPARE = 3'd6;
   localparam logic [1:0] TX_NONE    = 2'd0;

   typedef struct packed {
      logic [2:0]  func;
      logic [2:0]  slot;
      logic [15:0] port;
      logic [2:0]  rx_type;
      logic [15:0] rx_dest_port;
   } req_item_type;

   typedef struct {
      req_item_type item;
      bit           typed;
      kind_type     kind;
      logic [2:0]   entry;
   } step_row_type;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [2:0]  req_func;
   logic [2:0]  req_slot;
   logic [15:0] req_port;
   logic [2:0]  req_rx_type;
   logic [15:0] req_rx_dest_port;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [3:0]  rsp_kind;
   logic [2:0]  rsp_entry;
   logic [1:0]  rsp_tx_type;
   logic [15:0] rsp_tx_src_port;
   logic [15:0] rsp_tx_dest_port;
   logic        rsp_last;
   logic        csr_wen;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   // shadow copy of the connection table and its timing registers
   logic           tbl_valid [ENTRIES];
   logic [15:0]    tbl_cport [ENTRIES];
   logic [15:0]    tbl_sport [ENTRIES];
   conn_state_type tbl_cs    [ENTRIES];
   logic [7:0]     tbl_retry [ENTRIES];
   logic [15:0]    tbl_timer [ENTRIES];
   cfg_type        timing;

   rsp_type      pending_rsp [$];
   int           mismatches;
   bit           idle_on;
   int           hold_asks;
   int           hold_seen;
   int           hold_left;
   int           rx_gap;
   step_row_type dir_rows [0:25];

   connection_handshake_table_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_func         (req_func),
      .req_slot         (req_slot),
      .req_port         (req_port),
      .req_rx_type      (req_rx_type),
      .req_rx_dest_port (req_rx_dest_port),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_kind         (rsp_kind),
      .rsp_entry        (rsp_entry),
      .rsp_tx_type      (rsp_tx_type),
      .rsp_tx_src_port  (rsp_tx_src_port),
      .rsp_tx_dest_port (rsp_tx_dest_port),
      .rsp_last         (rsp_last),
      .csr_wen          (csr_wen),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   task automatic flag_mismatch(input string msg);
      mismatches++;
      $display("MISMATCH @%0t: %s", $time, msg);
   endtask

   function automatic void add_rsp(ref rsp_type q[$], input kind_type k, input int ent,
                                   input logic [1:0] txt, input logic [15:0] src,
                                   input logic [15:0] dst);
      rsp_type r;
      if (q.size() >= MAX_RESULTS) return;
      r.kind         = k;
      r.entry        = ent[2:0];
      r.tx_type      = txt;
      r.tx_src_port  = src;
      r.tx_dest_port = dst;
      r.last         = 1'b0;
      q.push_back(r);
   endfunction

   // work out the results of one transaction and advance the shadow table
   function automatic void predict_table(input req_item_type it, ref rsp_type q[$]);
      int   hit;
      int   i;
      logic syn;
      hit = -1;
      case (it.func)
         FUNC_OPEN: begin
            for (i = 0; i < ENTRIES; i++)
               if (!tbl_valid[i] && hit < 0) hit = i;
            if (hit < 0) begin
               add_rsp(q, KIND_TABLE_FULL, 0, TX_NONE, 16'd0, 16'd0);
            end else begin
               tbl_valid[hit] = 1'b1;
               tbl_cport[hit] = it.port;
               tbl_sport[hit] = 16'd0;
               tbl_cs[hit]    = CS_CLOSED;
               tbl_retry[hit] = 8'd0;
               tbl_timer[hit] = 16'd0;
               add_rsp(q, KIND_OK, hit, TX_NONE, 16'd0, 16'd0);
            end
         end
         FUNC_CONNECT, FUNC_DISCONNECT, FUNC_CLOSE: begin
            if (!tbl_valid[it.slot]) begin
               add_rsp(q, KIND_NO_ENTRY, it.slot, TX_NONE, 16'd0, 16'd0);
            end else if (it.func == FUNC_CONNECT) begin
               tbl_sport[it.slot] = it.port;
               tbl_cs[it.slot]    = CS_SYNSENT;
               tbl_retry[it.slot] = 8'd0;
               tbl_timer[it.slot] = 16'd0;
               add_rsp(q, KIND_SEND, it.slot, SEG_SYN, tbl_cport[it.slot], tbl_sport[it.slot]);
            end else if (it.func == FUNC_DISCONNECT) begin
               if (tbl_cs[it.slot] != CS_CONNECTED) begin
                  add_rsp(q, KIND_BAD_STATE, it.slot, TX_NONE, 16'd0, 16'd0);
               end else begin
                  tbl_cs[it.slot]    = CS_FINWAIT;
                  tbl_retry[it.slot] = 8'd0;
                  tbl_timer[it.slot] = 16'd0;
                  add_rsp(q, KIND_SEND, it.slot, SEG_FIN, tbl_cport[it.slot],
                          tbl_sport[it.slot]);
               end
            end else begin
               tbl_valid[it.slot] = 1'b0;
               add_rsp(q, (tbl_cs[it.slot] == CS_CLOSED) ? KIND_OK : KIND_BAD_STATE,
                       it.slot, TX_NONE, 16'd0, 16'd0);
            end
         end
         FUNC_SEGMENT: begin
            if (it.rx_type == RX_SYNACK || it.rx_type == RX_FINACK) begin
               for (i = 0; i < ENTRIES; i++)
                  if (hit < 0 && tbl_valid[i] && tbl_cport[i] == it.rx_dest_port) hit = i;
               if (hit < 0) begin
                  add_rsp(q, KIND_UNKNOWN_PORT, 0, TX_NONE, 16'd0, 16'd0);
               end else if (it.rx_type == RX_SYNACK) begin
                  if (tbl_cs[hit] == CS_SYNSENT) begin
                     tbl_cs[hit] = CS_CONNECTED;
                     add_rsp(q, KIND_CONNECTED, hit, TX_NONE, 16'd0, 16'd0);
                  end else begin
                     add_rsp(q, (tbl_cs[hit] == CS_CONNECTED) ? KIND_REPEAT_ACK : KIND_BAD_STATE,
                             hit, TX_NONE, 16'd0, 16'd0);
                  end
               end else begin
                  if (tbl_cs[hit] == CS_FINWAIT) begin
                     tbl_cs[hit]    = CS_CLOSED;
                     tbl_sport[hit] = 16'd0;
                     add_rsp(q, KIND_DISCONNECTED, hit, TX_NONE, 16'd0, 16'd0);
                  end else begin
                     add_rsp(q, (tbl_cs[hit] == CS_CLOSED) ? KIND_REPEAT_ACK : KIND_BAD_STATE,
                             hit, TX_NONE, 16'd0, 16'd0);
                  end
               end
            end
         end
         FUNC_TICK: begin
            // age waiting entries, resend on timeout, fail once retries run out
            for (i = 0; i < ENTRIES; i++) begin
               if (tbl_valid[i] && (tbl_cs[i] == CS_SYNSENT || tbl_cs[i] == CS_FINWAIT)) begin
                  syn = (tbl_cs[i] == CS_SYNSENT);
                  tbl_timer[i] = tbl_timer[i] + 16'd1;
                  if (tbl_timer[i] >= (syn ? timing.syn_timeout_ticks
                                           : timing.fin_timeout_ticks)) begin
                     tbl_timer[i] = 16'd0;
                     tbl_retry[i] = tbl_retry[i] + 8'd1;
                     if (tbl_retry[i] >= (syn ? timing.syn_retry_limit
                                              : timing.fin_retry_limit)) begin
                        tbl_cs[i]    = CS_CLOSED;
                        tbl_sport[i] = 16'd0;
                        add_rsp(q, syn ? KIND_CONN_FAIL : KIND_DISC_TIMEOUT, i, TX_NONE,
                                16'd0, 16'd0);
                     end else begin
                        add_rsp(q, KIND_SEND, i, syn ? SEG_SYN : SEG_FIN, tbl_cport[i],
                                tbl_sport[i]);
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      if (q.size() > 0) q[q.size() - 1].last = 1'b1;
   endfunction

   // offer one transaction, then queue what it should produce once it is taken
   task automatic offer(input req_item_type it, input bit typed, input kind_type tk,
                        input logic [2:0] te);
      int      gap;
      rsp_type outcome [$];
      rsp_type fixed_rsp;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         @(negedge clock);
         req_push <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_push         <= 1'b1;
      req_func         <= it.func;
      req_slot         <= it.slot;
      req_port         <= it.port;
      req_rx_type      <= it.rx_type;
      req_rx_dest_port <= it.rx_dest_port;
      do @(posedge clock); while (req_full);
      predict_table(it, outcome);
      if (typed) begin
         fixed_rsp = '{kind: tk, entry: te, tx_type: TX_NONE, tx_src_port: 16'd0,
                       tx_dest_port: 16'd0, last: 1'b1};
         outcome.delete();
         outcome.push_back(fixed_rsp);
      end
      foreach (outcome[k]) pending_rsp.push_back(outcome[k]);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
   endtask

   // load all four timing registers; junk in the upper byte of the retry limits
   task automatic set_timing(input logic [15:0] syn_to, input logic [7:0] syn_lim,
                             input logic [15:0] fin_to, input logic [7:0] fin_lim);
      write_csr(CSR_SYN_TIMEOUT, syn_to);
      write_csr(CSR_SYN_RETRY, {8'($urandom), syn_lim});
      write_csr(CSR_FIN_TIMEOUT, fin_to);
      write_csr(CSR_FIN_RETRY, {8'($urandom), fin_lim});
      @(negedge clock);
      csr_wen <= 1'b0;
      timing.syn_timeout_ticks = syn_to;
      timing.syn_retry_limit   = syn_lim;
      timing.fin_timeout_ticks = fin_to;
      timing.fin_retry_limit   = fin_lim;
   endtask

   // drop push, let every expected result drain, then allow silent work to finish
   task automatic settle();
      @(negedge clock);
      req_push <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // favour live entries, and those in the wanted state where asked
   function automatic logic [2:0] pick_slot(input bit by_state, input conn_state_type want);
      int hits [$];
      int live [$];
      int i;
      for (i = 0; i < ENTRIES; i++) begin
         if (tbl_valid[i]) begin
            live.push_back(i);
            if (tbl_cs[i] == want) hits.push_back(i);
         end
      end
      if ($urandom_range(0, 9) == 0) return 3'($urandom);
      if (by_state && hits.size() > 0) return 3'(hits[$urandom_range(0, hits.size() - 1)]);
      if (live.size() > 0) return 3'(live[$urandom_range(0, live.size() - 1)]);
      return 3'($urandom);
   endfunction

   function automatic req_item_type pick_item();
      req_item_type it;
      int           roll;
      logic [2:0]   s;
      it.func         = FUNC_TICK;
      it.slot         = 3'($urandom);
      it.port         = 16'($urandom);
      it.rx_type      = 3'($urandom);
      it.rx_dest_port = 16'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
         it.func = 3'($urandom);
      end else if (roll < 27) begin
         it.func = FUNC_OPEN;
         // reuse a client port now and then so matching takes the lowest entry
         if ($urandom_range(0, 3) == 0) it.port = tbl_cport[pick_slot(1'b0, CS_CLOSED)];
      end else if (roll < 42) begin
         it.func = FUNC_CONNECT;
         it.slot = pick_slot(1'b1, CS_CLOSED);
      end else if (roll < 54) begin
         it.func = FUNC_DISCONNECT;
         it.slot = pick_slot(1'b1, CS_CONNECTED);
      end else if (roll < 62) begin
         it.func = FUNC_CLOSE;
         it.slot = pick_slot(1'b0, CS_CLOSED);
      end else if (roll < 80) begin
         it.func = FUNC_SEGMENT;
         s = pick_slot(1'b1, $urandom_range(0, 1) ? CS_SYNSENT : CS_FINWAIT);
         if (tbl_cs[s] == CS_SYNSENT)      it.rx_type = RX_SYNACK;
         else if (tbl_cs[s] == CS_FINWAIT) it.rx_type = RX_FINACK;
         else it.rx_type = $urandom_range(0, 1) ? RX_SYNACK : RX_FINACK;
         if ($urandom_range(0, 7) != 0) it.rx_dest_port = tbl_cport[s];
      end
      return it;
   endfunction

   // random transactions; ignored ones do not count towards the goal
   task automatic run_random(input int goal, input bit calm);
      int           done_cnt;
      req_item_type it;
      done_cnt = 0;
      while (done_cnt < goal) begin
         idle_on = !calm && ((done_cnt / 15) % 2 == 0);
         it = pick_item();
         offer(it, 1'b0, KIND_OK, 3'd0);
         if (it.func <= FUNC_TICK &&
             !(it.func == FUNC_SEGMENT && it.rx_type != RX_SYNACK && it.rx_type != RX_FINACK))
            done_cnt++;
      end
   endtask

   // receiver: random pop bursts, and a long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_pop <= 1'b0;
      end else if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES - 1;
         rsp_pop <= 1'b0;
      end else if (rx_gap > 0) begin
         rx_gap = rx_gap - 1;
         rsp_pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         rx_gap = $urandom_range(1, 18) - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // check each popped result against the oldest expectation
   always @(posedge clock) begin : result_check
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         got = rsp_type'({rsp_kind, rsp_entry, rsp_tx_type, rsp_tx_src_port,
                          rsp_tx_dest_port, rsp_last});
         if (pending_rsp.size() == 0) begin
            flag_mismatch($sformatf("unexpected result kind %0d entry %0d", rsp_kind,
                                    rsp_entry));
         end else begin
            want = pending_rsp.pop_front();
            if (got !== want)
               flag_mismatch($sformatf(
                  "got kind %0d ent %0d tx %0d src %h dst %h last %b, want %0d %0d %0d %h %h %b",
                  got.kind, got.entry, got.tx_type, got.tx_src_port, got.tx_dest_port,
                  got.last, want.kind, want.entry, want.tx_type, want.tx_src_port,
                  want.tx_dest_port, want.last));
         end
      end
   end

   initial begin
      #5_000_000;
      $display("connection_handshake_table_core test failed");
      $finish;
   end

   initial begin : main
      int r;
      clock            = 1'b0;
      reset            = 1'b1;
      req_push         = 1'b0;
      req_func         = 3'd0;
      req_slot         = 3'd0;
      req_port         = 16'd0;
      req_rx_type      = 3'd0;
      req_rx_dest_port = 16'd0;
      rsp_pop          = 1'b0;
      csr_wen          = 1'b0;
      csr_index        = 2'd0;
      csr_wdata        = 16'd0;
      mismatches       = 0;
      idle_on          = 1'b1;
      hold_asks        = 0;
      hold_seen        = 0;
      hold_left        = 0;
      rx_gap           = 0;
      for (r = 0; r < ENTRIES; r++) begin
         tbl_valid[r] = 1'b0;
         tbl_cport[r] = 16'd0;
         tbl_sport[r] = 16'd0;
         tbl_cs[r]    = CS_CLOSED;
         tbl_retry[r] = 8'd0;
         tbl_timer[r] = 16'd0;
      end
      timing = '{syn_timeout_ticks: 16'd1000, syn_retry_limit: 8'd5,
                 fin_timeout_ticks: 16'd1000, fin_retry_limit: 8'd5};

      dir_rows = '{
         '{'{FUNC_SEGMENT,    3'd0, 16'h0000, RX_SYNACK, 16'h1234}, 1'b1, KIND_UNKNOWN_PORT, 3'd0},
         '{'{FUNC_CONNECT,    3'd3, 16'h0001, RX_SYN,    16'h0000}, 1'b1, KIND_NO_ENTRY,     3'd3},
         '{'{FUNC_CLOSE,      3'd7, 16'h0000, RX_SYN,    16'h0000}, 1'b1, KIND_NO_ENTRY,     3'd7},
         '{'{FUNC_OPEN,       3'd0, 16'h0000, RX_SYN,    16'h0000}, 1'b1, KIND_OK,           3'd0},
         '{'{FUNC_OPEN,       3'd0, 16'hFFFF, RX_SYN,    16'h0000}, 1'b1, KIND_OK,           3'd1},
         '{'{FUNC_DISCONNECT, 3'd0, 16'h0000, RX_SYN,    16'h0000}, 1'b1, KIND_BAD_STATE,    3'd0},
         '{'{FUNC_CONNECT,    3'd0, 16'hFFFF, RX_SYN,    16'h0000}, 1'b0, KIND_OK,           3'd0},
         '{'{FUNC_SEGMENT,    3'd0, 16'h0000, RX_SYNACK, 16'h0000}, 1'b1, KIND_CONNECTED,    3'd0},
         '{'{FUNC_SEGMENT,    3'd0, 16'h0000, RX_SYNACK, 16'h0000}, 1'b1, KIND_REPEAT_ACK,   3'd0},
         '{'{FUNC_SEGMENT,    3'd0, 16'h0000, RX_FINACK, 16'h0000}, 1'b1, KIND_BAD_STATE,    3'd0},
         '{'{FUNC_DISCONNECT, 3'd0, 16'h0000, RX_SYN,    16'h0000}, 1'b0, KIND_OK,           3'd0},
         '{'{FUNC_TICK,       3'd0, 16'h0000, RX_SYN,    16'h0000}, 1'b0, KIND_OK,           3'd0},
         '{'{FUNC_SEGMENT,    3'd0, 16'h0000, RX_FINACK, 16'h0000}, 1'b1, KIND_DISCONNECTED, 3'd0},
         '{'{FUNC_SEGMENT,    3'd0, 16'h0000, RX_FINACK, 16'h0000}, 1'b1, KIND_REPEAT_ACK,   3'd0},
         '{'{FUNC_SEGMENT,    3'd0, 16'h0000, RX_SYNACK, 16'hFFFF}, 1'b1, KIND_BAD_STATE,    3'd1},
         '{'{FUNC_CONNECT,    3'd1, 16'h8000, RX_SYN,    16'h0000}, 1'b0, KIND_OK,           3'd0},
         '{'{FUNC_SEGMENT,    3'd0, 16'h0000, RX_SYN,    16'hFFFF}, 1'b0, KIND_OK,           3'd0},
         '{'{FUNC_SEGMENT,    3'd0, 16'h0000, RX_ODD,    16'hFFFF}, 1'b0, KIND_OK,           3'd0},
         '{'{FUNC_SPARE,      3'd7, 16'hFFFF, RX_ODD,    16'hFFFF}, 1'b0, KIND_OK,           3'd0},
         '{'{FUNC_TICK,       3'd0, 16'h0000, RX_SYN,    16'h0000}, 1'b0, KIND_OK,           3'd0},
         '{'{FUNC_TICK,       3'd0, 16'h0000, RX_SYN,    16'h0000}, 1'b0, KIND_OK,           3'd0},
         '{'{FUNC_TICK,       3'd0, 16'h0000, RX_SYN,    16'h0000}, 1'b0, KIND_OK,           3'd0},
         '{'{FUNC_TICK,       3'd0, 16'h0000, RX_SYN,    16'h0000}, 1'b0, KIND_OK,           3'd0},
         '{'{FUNC_CONNECT,    3'd0, 16'h5A5A, RX_SYN,    16'h0000}, 1'b0, KIND_OK,           3'd0},
         '{'{FUNC_CLOSE,      3'd0, 16'h0000, RX_SYN,    16'h0000}, 1'b1, KIND_BAD_STATE,    3'd0},
         '{'{FUNC_CLOSE,      3'd1, 16'h0000, RX_SYN,    16'h0000}, 1'b1, KIND_OK,           3'd1}
      };

      // hold reset, then release on a falling edge
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed walk with short timeouts so resend and failure show up quickly
      set_timing(16'd2, 8'd2, 16'd1, 8'd2);
      foreach (dir_rows[k])
         offer(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].kind, dir_rows[k].entry);
      settle();

      // lowest register settings: every wait fails on its first timeout
      set_timing(16'd1, 8'd1, 16'd1, 8'd1);
      run_random(38, 1'b0);
      settle();

      // small random settings, with a long receiver hold-off to back up the input
      set_timing(16'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
                 16'($urandom_range(1, 4)), 8'($urandom_range(1, 4)));
      hold_asks = hold_asks + 1;
      run_random(38, 1'b0);
      settle();

      // highest register settings
      set_timing(16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF);
      run_random(38, 1'b0);
      settle();

      // closing stretch with no idling on either side
      set_timing(16'($urandom_range(1, 3)), 8'($urandom_range(2, 6)),
                 16'($urandom_range(1, 3)), 8'($urandom_range(2, 6)));
      idle_on = 1'b0;
      run_random(38, 1'b1);
      settle();

      if (pending_rsp.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", pending_rsp.size()));
      if (mismatches == 0) begin
         $display("connection_handshake_table_core test passed");
      end else begin
         $display("connection_handshake_table_core test failed");
      end
      $finish;
   end

endmodule

FILE: connection_handshake_table_core.f
src/chtbl_pkg.sv
src/chtbl_fifo.sv
src/chtbl_front.sv
src/chtbl_engine.sv
src/connection_handshake_table_core.sv
src/chtbl_checker.sv
sim/tb.sv
